// ===== sv/mhpq_pkg.sv =====
// types, constants and helpers shared by the min-heap priority queue modules
// no dependencies

package mhpq_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned HANDLES  = 1024;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned DELTA_W  = 63;
  localparam int unsigned HANDLE_W = 10;
  localparam int unsigned SLOT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned HADDR_W  = $clog2(HANDLES);

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_GET_MIN = 2'd1,
    REQ_EXTRACT = 2'd2,
    REQ_DECREASE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_INUSE   = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [KEY_W-1:0] key_value;
    logic [HANDLE_W-1:0]     handle;
    logic [DELTA_W-1:0]      delta;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] min_value;
    logic [2:0]              status;
    logic [SLOT_W-1:0]       entry_count;
  } res_t;

  // one heap slot
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [HANDLE_W-1:0]     handle;
  } entry_t;

  // datapath actions requested by the controller
  typedef struct packed {
    logic    accept;
    logic    clr;
    logic    ins;
    logic    ext;
    logic    ext_last;
    logic    dec_rd;
    logic    dec_ld;
    logic    up_rd;
    logic    up_mv;
    logic    dn_rdl;
    logic    dn_ll;
    logic    dn_rdr;
    logic    dn_pr;
    logic    dn_mv;
    logic    place;
    logic    st_we;
    status_e st_code;
  } cmd_t;

  // conditions reported back to the controller
  typedef struct packed {
    req_e req;
    logic bad_handle;
    logic hs_used;
    logic full;
    logic empty;
    logic cnt_one;
    logic s_one;
    logic has_left;
    logic has_right;
    logic up_less;
    logic right_less;
    logic dn_less;
    logic clr_last;
  } stat_t;

  // heap slot number (1-based) to memory address
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W:0] slot);
    logic [SLOT_W:0] a;
    a = slot - 1'b1;
    return a[ADDR_W-1:0];
  endfunction

endpackage

// ===== sv/mhpq_ctrl.sv =====
// controller state machine of the min-heap priority queue
// depends on mhpq_pkg

module mhpq_ctrl import mhpq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy,
  output logic  done_o
);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_LOOK   = 12'b000000000100,
    S_DEC    = 12'b000000001000,
    S_UP     = 12'b000000010000,
    S_UP_CMP = 12'b000000100000,
    S_DN     = 12'b000001000000,
    S_DN_L   = 12'b000010000000,
    S_DN_R   = 12'b000100000000,
    S_DN_CMP = 12'b001000000000,
    S_PLACE  = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.st_code = ST_OK;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_DONE;
        unique case (stat_i.req)
          REQ_INSERT: begin
            if (stat_i.bad_handle) begin
              cmd_o.st_we = 1'b1;
              cmd_o.st_code = ST_UNKNOWN;
            end else if (stat_i.hs_used) begin
              cmd_o.st_we = 1'b1;
              cmd_o.st_code = ST_INUSE;
            end else if (stat_i.full) begin
              cmd_o.st_we = 1'b1;
              cmd_o.st_code = ST_FULL;
            end else begin
              cmd_o.ins = 1'b1;
              state_d = S_UP;
            end
          end
          REQ_GET_MIN: begin
            if (stat_i.empty) begin
              cmd_o.st_we = 1'b1;
              cmd_o.st_code = ST_EMPTY;
            end
          end
          REQ_EXTRACT: begin
            if (stat_i.empty) begin
              cmd_o.st_we = 1'b1;
              cmd_o.st_code = ST_EMPTY;
            end else if (stat_i.cnt_one) begin
              cmd_o.ext_last = 1'b1;
            end else begin
              cmd_o.ext = 1'b1;
              state_d = S_DN;
            end
          end
          REQ_DECREASE: begin
            if (stat_i.bad_handle || !stat_i.hs_used) begin
              cmd_o.st_we = 1'b1;
              cmd_o.st_code = ST_UNKNOWN;
            end else begin
              cmd_o.dec_rd = 1'b1;
              state_d = S_DEC;
            end
          end
          default: ;
        endcase
      end
      S_DEC: begin
        cmd_o.dec_ld = 1'b1;
        state_d = S_UP;
      end
      S_UP: begin
        if (stat_i.s_one) begin
          state_d = S_PLACE;
        end else begin
          cmd_o.up_rd = 1'b1;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat_i.up_less) begin
          cmd_o.up_mv = 1'b1;
          state_d = S_UP;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_DN: begin
        if (stat_i.has_left) begin
          cmd_o.dn_rdl = 1'b1;
          state_d = S_DN_L;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_DN_L: begin
        cmd_o.dn_ll = 1'b1;
        if (stat_i.has_right) begin
          cmd_o.dn_rdr = 1'b1;
          state_d = S_DN_R;
        end else begin
          state_d = S_DN_CMP;
        end
      end
      S_DN_R: begin
        cmd_o.dn_pr = stat_i.right_less;
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat_i.dn_less) begin
          cmd_o.dn_mv = 1'b1;
          state_d = S_DN;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

// ===== sv/mhpq_datapath.sv =====
// heap and handle-position memories, sift registers and result registers
// depends on mhpq_pkg

module mhpq_datapath import mhpq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  req_t  req_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output res_t  res_o
);

  entry_t             heap_mem [CAPACITY];
  logic [SLOT_W-1:0]  hs_mem   [HANDLES];

  req_t               req_q;
  logic [SLOT_W-1:0]  count_q;
  logic [SLOT_W-1:0]  s_q;
  logic [SLOT_W-1:0]  c_q;
  entry_t             cur_q;
  entry_t             child_q;
  entry_t             top_q;
  status_e            status_q;
  logic [HADDR_W-1:0] clr_q;
  entry_t             heap_rd_q;
  logic [SLOT_W-1:0]  hs_rd_q;

  logic [SLOT_W:0]    left_w, right_w, parent_w;
  logic [ADDR_W-1:0]  heap_raddr;
  logic               heap_we;
  logic [SLOT_W-1:0]  heap_wslot;
  entry_t             heap_wdata;
  logic               hs_we;
  logic [HADDR_W-1:0] hs_waddr;
  logic [SLOT_W-1:0]  hs_wdata;

  assign left_w   = {s_q, 1'b0};
  assign right_w  = {s_q, 1'b1};
  assign parent_w = {2'b00, s_q[SLOT_W-1:1]};

  // heap read address
  always_comb begin
    priority if (cmd_i.dec_rd) heap_raddr = slot_addr({1'b0, hs_rd_q});
    else if (cmd_i.up_rd)      heap_raddr = slot_addr(parent_w);
    else if (cmd_i.dn_rdl)     heap_raddr = slot_addr(left_w);
    else if (cmd_i.dn_rdr)     heap_raddr = slot_addr(right_w);
    else                       heap_raddr = slot_addr({1'b0, count_q});
  end

  // heap write port
  always_comb begin
    heap_we    = cmd_i.up_mv | cmd_i.dn_mv | cmd_i.place;
    heap_wslot = s_q;
    priority if (cmd_i.up_mv) heap_wdata = heap_rd_q;
    else if (cmd_i.dn_mv)     heap_wdata = child_q;
    else                      heap_wdata = cur_q;
  end

  // position table write port
  always_comb begin
    hs_we    = cmd_i.clr | cmd_i.ext | cmd_i.ext_last | heap_we;
    hs_wdata = s_q;
    priority if (cmd_i.clr) begin
      hs_waddr = clr_q;
      hs_wdata = '0;
    end else if (cmd_i.ext || cmd_i.ext_last) begin
      hs_waddr = top_q.handle[HADDR_W-1:0];
      hs_wdata = '0;
    end else begin
      hs_waddr = heap_wdata.handle[HADDR_W-1:0];
    end
  end

  // memories with registered reads
  always_ff @(posedge clk_i) begin
    if (heap_we) heap_mem[slot_addr({1'b0, heap_wslot})] <= heap_wdata;
    heap_rd_q <= heap_mem[heap_raddr];
    if (hs_we) hs_mem[hs_waddr] <= hs_wdata;
    hs_rd_q <= hs_mem[req_i.handle[HADDR_W-1:0]];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      clr_q    <= '0;
      status_q <= ST_OK;
    end else begin
      if (cmd_i.clr) clr_q <= clr_q + 1'b1;
      if (cmd_i.accept) status_q <= ST_OK;
      else if (cmd_i.st_we) status_q <= cmd_i.st_code;
      if (cmd_i.ins) count_q <= count_q + 1'b1;
      else if (cmd_i.ext || cmd_i.ext_last) count_q <= count_q - 1'b1;
    end
  end

  // sift registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) req_q <= req_i;
    if (cmd_i.ins) begin
      cur_q <= '{key: req_q.key_value, handle: req_q.handle};
      s_q   <= count_q + 1'b1;
    end
    if (cmd_i.ext) begin
      cur_q <= heap_rd_q;
      s_q   <= SLOT_W'(1);
    end
    if (cmd_i.dec_rd) s_q <= hs_rd_q;
    if (cmd_i.dec_ld) begin
      cur_q <= '{key: heap_rd_q.key - $signed({1'b0, req_q.delta}),
                 handle: heap_rd_q.handle};
    end
    if (cmd_i.up_mv) s_q <= parent_w[SLOT_W-1:0];
    if (cmd_i.dn_ll) begin
      child_q <= heap_rd_q;
      c_q     <= left_w[SLOT_W-1:0];
    end
    if (cmd_i.dn_pr) begin
      child_q <= heap_rd_q;
      c_q     <= right_w[SLOT_W-1:0];
    end
    if (cmd_i.dn_mv) s_q <= c_q;
    if (heap_we && heap_wslot == SLOT_W'(1)) top_q <= heap_wdata;
  end

  // status toward the controller
  always_comb begin
    stat_o.req        = req_e'(req_q.req_type);
    stat_o.bad_handle = ({1'b0, req_q.handle} >= (HANDLE_W+1)'(HANDLES));
    stat_o.hs_used    = (hs_rd_q != '0);
    stat_o.full       = (count_q >= SLOT_W'(CAPACITY));
    stat_o.empty      = (count_q == '0);
    stat_o.cnt_one    = (count_q == SLOT_W'(1));
    stat_o.s_one      = (s_q == SLOT_W'(1));
    stat_o.has_left   = (left_w <= {1'b0, count_q});
    stat_o.has_right  = (right_w <= {1'b0, count_q});
    stat_o.up_less    = (cur_q.key < heap_rd_q.key);
    stat_o.right_less = (heap_rd_q.key < child_q.key);
    stat_o.dn_less    = (child_q.key < cur_q.key);
    stat_o.clr_last   = (clr_q == HADDR_W'(HANDLES - 1));
  end

  // result fields
  assign res_o.min_value   = (count_q != '0) ? top_q.key : '0;
  assign res_o.status      = status_q;
  assign res_o.entry_count = count_q;

  heap_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SLOT_W'(CAPACITY))
    else $error("entry count above capacity");
  insert_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins |-> count_q < SLOT_W'(CAPACITY))
    else $error("insert into full heap");
  extract_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ext || cmd_i.ext_last) |-> count_q != '0)
    else $error("extract from empty heap");

endmodule

// ===== sv/min_heap_priority_queue_unit.sv =====
// top level of the binary min-heap priority queue with handles
// depends on mhpq_pkg, mhpq_ctrl, mhpq_datapath
//
// usage: a request (insert, get minimum, extract minimum, decrease key) is
// taken by a transfer at a rising edge with start high and busy low. the
// result (min_value, status, entry_count) appears on res_o for exactly one
// cycle with done_o high; the receiver cannot stall it.
// get minimum, every error and extract of the last entry go from the
// request lookup straight to the result. insert sifts the new entry up;
// decrease first reads the entry, then sifts it up. extract moves the last
// entry to the root and sifts it down, reading the left and, where there
// is one, the right child at each level. the single read port of the heap
// memory is read once or twice per level. one request is handled at a time;
// busy stays high until the cycle after done_o, so a new transfer is taken
// only after the result of the last one.
// reset: the handle position table is cleared by a pass over its 1024
// entries, one entry a cycle; busy is high through it and the heap is
// empty after.

module min_heap_priority_queue_unit import mhpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic done_o,
  output res_t res_o
);

  cmd_t  cmd;
  stat_t stat;

  // controller
  mhpq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // datapath
  mhpq_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res_o)
  );

  start_takes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy && !done_o)
    else $error("transfer did not make the unit busy");
  done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe longer than one cycle");
  done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result without request in flight");

endmodule

// ===== test/min_heap_priority_queue_unit_tb.sv =====
// testbench for the binary min-heap priority queue with handles
// depends on mhpq_pkg and min_heap_priority_queue_unit; checks every result
// against a behavioral heap model kept alongside the stimulus
`timescale 1ns / 1ps

module min_heap_priority_queue_unit_tb;
  import mhpq_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req_i = '0;
  logic busy;
  logic done_o;
  res_t res_o;

  min_heap_priority_queue_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #6 clk_i = ~clk_i;

  // behavioral heap, 1-based slots
  logic signed [KEY_W-1:0] mdl_keys [CAPACITY+1];
  logic [HANDLE_W-1:0]     mdl_handles [CAPACITY+1];
  int unsigned             mdl_slot [HANDLES];
  int unsigned             mdl_count;

  res_t result_queue [$];
  int   mismatch_count = 0;
  int   idle_cycles = 0;
  bit   timed_out = 1'b0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic void heap_swap(input int unsigned a, input int unsigned b);
    logic signed [KEY_W-1:0] k;
    logic [HANDLE_W-1:0] h;
    k = mdl_keys[a]; h = mdl_handles[a];
    mdl_keys[a] = mdl_keys[b]; mdl_handles[a] = mdl_handles[b];
    mdl_keys[b] = k; mdl_handles[b] = h;
    mdl_slot[mdl_handles[a]] = a;
    mdl_slot[mdl_handles[b]] = b;
  endfunction

  function automatic void heap_sift_up(input int unsigned s);
    while (s > 1 && mdl_keys[s] < mdl_keys[s/2]) begin
      heap_swap(s, s/2);
      s = s / 2;
    end
  endfunction

  function automatic void heap_sift_down(input int unsigned s);
    int unsigned c;
    while (2*s <= mdl_count) begin
      c = 2*s;
      if (c+1 <= mdl_count && mdl_keys[c+1] < mdl_keys[c]) c = c + 1;
      if (!(mdl_keys[c] < mdl_keys[s])) break;
      heap_swap(s, c);
      s = c;
    end
  endfunction

  // apply one request to the heap model and return the expected result
  function automatic res_t heap_apply(input req_t r);
    res_t o;
    status_e st;
    int unsigned s;
    st = ST_OK;
    case (req_e'(r.req_type))
      REQ_INSERT: begin
        if (mdl_slot[r.handle] != 0) st = ST_INUSE;
        else if (mdl_count >= CAPACITY) st = ST_FULL;
        else begin
          mdl_count++;
          mdl_keys[mdl_count] = r.key_value;
          mdl_handles[mdl_count] = r.handle;
          mdl_slot[r.handle] = mdl_count;
          heap_sift_up(mdl_count);
        end
      end
      REQ_GET_MIN: begin
        if (mdl_count == 0) st = ST_EMPTY;
      end
      REQ_EXTRACT: begin
        if (mdl_count == 0) st = ST_EMPTY;
        else begin
          mdl_slot[mdl_handles[1]] = 0;
          if (mdl_count > 1) begin
            mdl_keys[1] = mdl_keys[mdl_count];
            mdl_handles[1] = mdl_handles[mdl_count];
            mdl_slot[mdl_handles[1]] = 1;
          end
          mdl_count--;
          heap_sift_down(1);
        end
      end
      default: begin
        if (mdl_slot[r.handle] == 0) st = ST_UNKNOWN;
        else begin
          s = mdl_slot[r.handle];
          mdl_keys[s] = mdl_keys[s] - $signed({1'b0, r.delta});
          heap_sift_up(s);
        end
      end
    endcase
    o.min_value = (mdl_count > 0) ? mdl_keys[1] : '0;
    o.status = st;
    o.entry_count = mdl_count[SLOT_W-1:0];
    return o;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t make_req(input req_e t, input logic [63:0] k,
                                    input int unsigned h, input logic [62:0] d);
    req_t r;
    r.req_type = t; r.key_value = k; r.handle = h[HANDLE_W-1:0]; r.delta = d;
    return r;
  endfunction

  // sender with bursts and gaps; transfer happens at an edge with busy low
  int burst_left = 0;

  task automatic send_req(input req_t r, input bit has_fixed, input res_t fixed);
    res_t exp_res;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 30));
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    exp_res = heap_apply(r);
    if (has_fixed && exp_res != fixed)
      report_mismatch($sformatf("model disagrees with table row %h", r));
    result_queue.push_back(exp_res);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (result_queue.size() == 0) report_mismatch("result with no request");
      else begin
        res_t e;
        e = result_queue.pop_front();
        if (res_o.min_value !== e.min_value)
          report_mismatch($sformatf("min_value %0d exp %0d", res_o.min_value,
                                    e.min_value));
        if (res_o.status !== e.status)
          report_mismatch($sformatf("status %0d exp %0d", res_o.status, e.status));
        if (res_o.entry_count !== e.entry_count)
          report_mismatch($sformatf("entry_count %0d exp %0d", res_o.entry_count,
                                    e.entry_count));
      end
    end
  end

  // watchdog on cycles with no transfer or result
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  typedef struct {
    req_t r;
    bit   has_fixed;
    res_t fixed;
  } row_t;

  function automatic res_t res_of(input logic [63:0] m, input status_e s,
                                  input int unsigned c);
    res_t o;
    o.min_value = m; o.status = s; o.entry_count = c[SLOT_W-1:0];
    return o;
  endfunction

  function automatic row_t row(input req_t r, input bit f, input res_t e);
    row_t x;
    x.r = r; x.has_fixed = f; x.fixed = e;
    return x;
  endfunction

  row_t directed [$];

  initial begin
    int unsigned h, n, pool;
    logic [63:0] k;
    req_e t;
    for (int i = 0; i <= CAPACITY; i++) begin
      mdl_keys[i] = '0; mdl_handles[i] = '0;
    end
    for (int i = 0; i < HANDLES; i++) mdl_slot[i] = 0;
    mdl_count = 0;

    // directed rows: empty cases, extremes, duplicates, wrap, unknown handle
    directed.push_back(row(make_req(REQ_GET_MIN, '0, 0, '0), 1, res_of('0, ST_EMPTY, 0)));
    directed.push_back(row(make_req(REQ_EXTRACT, '0, 0, '0), 1, res_of('0, ST_EMPTY, 0)));
    directed.push_back(row(make_req(REQ_DECREASE, '0, 5, 1), 1, res_of('0, ST_UNKNOWN, 0)));
    directed.push_back(row(make_req(REQ_INSERT, 64'h7fffffffffffffff, 1023, '0), 1,
                           res_of(64'h7fffffffffffffff, ST_OK, 1)));
    directed.push_back(row(make_req(REQ_INSERT, 64'h0, 1023, '0), 1,
                           res_of(64'h7fffffffffffffff, ST_INUSE, 1)));
    directed.push_back(row(make_req(REQ_INSERT, 64'h8000000000000000, 0, '0), 1,
                           res_of(64'h8000000000000000, ST_OK, 2)));
    directed.push_back(row(make_req(REQ_INSERT, 64'h5, 7, '0), 0, '0));
    directed.push_back(row(make_req(REQ_INSERT, 64'h5, 8, '0), 0, '0));
    directed.push_back(row(make_req(REQ_DECREASE, '0, 0, 63'h1), 0, '0));   // wraps high
    directed.push_back(row(make_req(REQ_DECREASE, '0, 1023, 63'h7fffffffffffffff), 0, '0));
    directed.push_back(row(make_req(REQ_DECREASE, '0, 8, 63'h0), 0, '0));
    directed.push_back(row(make_req(REQ_GET_MIN, '0, 0, '0), 0, '0));
    directed.push_back(row(make_req(REQ_EXTRACT, '0, 0, '0), 0, '0));
    directed.push_back(row(make_req(REQ_INSERT, 64'h3, 1023, '0), 0, '0)); // handle reuse
    for (int i = 0; i < 5; i++)
      directed.push_back(row(make_req(REQ_EXTRACT, '0, 0, '0), 0, '0));
    directed.push_back(row(make_req(REQ_GET_MIN, '0, 0, '0), 1, res_of('0, ST_EMPTY, 0)));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send_req(directed[i].r, directed[i].has_fixed, directed[i].fixed);

    // fill to capacity once, then decrease and partly drain the deep heap
    for (int i = 0; i < CAPACITY; i++)
      send_req(make_req(REQ_INSERT, rand64(), i, '0), 0, '0);
    send_req(make_req(REQ_INSERT, '0, 0, '0), 0, '0);
    send_req(make_req(REQ_EXTRACT, '0, 0, '0), 0, '0);
    send_req(make_req(REQ_INSERT, 64'h1, mdl_handles[1], '0), 0, '0);
    for (int i = 0; i < 100; i++)
      send_req(make_req(REQ_DECREASE, '0, $urandom_range(0, HANDLES-1),
                        63'({$urandom, $urandom} >> 1)), 0, '0);
    repeat (200) send_req(make_req(REQ_EXTRACT, '0, 0, '0), 0, '0);

    // random part; small handle pools keep hits on live handles and duplicates
    n = 0;
    while (n < 350) begin
      pool = ($urandom_range(0, 3) == 0) ? HANDLES : 32;
      repeat ($urandom_range(10, 60)) begin
        h = $urandom_range(0, pool - 1);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: t = REQ_INSERT;
          4:          t = REQ_GET_MIN;
          5, 6, 7:    t = REQ_EXTRACT;
          default:    t = REQ_DECREASE;
        endcase
        if ($urandom_range(0, 3) == 0) k = rand64();
        else k = 64'($signed($urandom_range(0, 200)) - 100);
        send_req(make_req(t, k, h,
                          ($urandom_range(0, 3) == 0) ? 63'(rand64() >> 1)
                                                      : 63'($urandom_range(0, 50))),
                 0, '0);
        n++;
      end
    end
    start <= 1'b0;

    while (result_queue.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== min_heap_priority_queue_unit.f =====
sv/mhpq_pkg.sv
sv/mhpq_ctrl.sv
sv/mhpq_datapath.sv
sv/min_heap_priority_queue_unit.sv
test/min_heap_priority_queue_unit_tb.sv
